### hw/rtl/plcm_pkg.sv
// Shared constants, command and status types for the piecewise-linear color map.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package plcm_pkg;

   // Table geometry.
   localparam int MAX_POINTS   = 16;
   localparam int NUM_CHANNELS = 3;
   localparam int DEPTH        = NUM_CHANNELS * MAX_POINTS;
   localparam int CNT_W        = $clog2(MAX_POINTS + 1);
   localparam int IDX_W        = $clog2(MAX_POINTS);
   localparam int ADDR_W       = $clog2(DEPTH);

   // Field widths.
   localparam int CH_W    = 2;
   localparam int X_W     = 32;
   localparam int Y_W     = 18;
   localparam int Y_FRAC  = 8;
   localparam int COLOR_W = 8;
   localparam int ENTRY_W = X_W + Y_W;

   // Arithmetic widths.
   localparam int D_W       = X_W + 1;
   localparam int PROD_W    = (Y_W + 1) + (D_W + 1);
   localparam int NUM_W     = PROD_W + 1;
   localparam int DIV_STEPS = COLOR_W + 1;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam int DIV_SHIFT = Y_FRAC + COLOR_W;
   localparam int HALF_Y    = 2 ** (Y_FRAC - 1);

   // Request action codes.
   localparam logic ACT_ADD = 1'b0;
   localparam logic ACT_MAP = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic set_k_count;
      logic dec_k;
      logic clr_k;
      logic inc_k;
      logic rd_at_km1;
      logic wr_shift;
      logic wr_point;
      logic inc_count;
      logic set_reject;
      logic latch_prev;
      logic latch_cur;
      logic mul;
      logic sum;
      logic div_step;
      logic next_chan;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic             is_map;
      logic             chan_bad;
      logic             table_full;
      logic             k_zero;
      logic             x_less;
      logic             few_points;
      logic             seg_found;
      logic             div_skip;
      logic             div_last;
      logic             last_chan;
      logic             rsp_busy;
      logic [CNT_W-1:0] count_cur;
   } status_type;

endpackage

### hw/rtl/plcm_if.sv
// Valid/ready channel interfaces for requests and responses of the color map.
// Depends on plcm_pkg for field widths.
interface plcm_req_if;
   logic                             valid;
   logic                             ready;
   logic                             action;
   logic [plcm_pkg::CH_W-1:0]        channel;
   logic signed [plcm_pkg::X_W-1:0]  point_x;
   logic signed [plcm_pkg::Y_W-1:0]  point_y;
   logic signed [plcm_pkg::X_W-1:0]  sample_value;

   modport source (output valid, action, channel, point_x, point_y, sample_value,
                   input ready);
   modport sink (input valid, action, channel, point_x, point_y, sample_value,
                 output ready);
endinterface

interface plcm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [plcm_pkg::COLOR_W-1:0]     red;
   logic [plcm_pkg::COLOR_W-1:0]     green;
   logic [plcm_pkg::COLOR_W-1:0]     blue;
   logic                             point_rejected;

   modport source (output valid, red, green, blue, point_rejected, input ready);
   modport sink (input valid, red, green, blue, point_rejected, output ready);
endinterface

### hw/rtl/plcm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module plcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/plcm_ctrl.sv
// Sequencer for point insertion and the three-channel lookup.
// Depends on plcm_pkg for the command and status types.
module plcm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  plcm_pkg::status_type status,
   output logic                 req_ready,
   output plcm_pkg::cmd_type    cmd
);
   import plcm_pkg::*;

   typedef enum logic [15:0] {
      S_IDLE      = 16'h0001,
      S_DISPATCH  = 16'h0002,
      S_ADD_CHECK = 16'h0004,
      S_ADD_TEST  = 16'h0008,
      S_ADD_READ  = 16'h0010,
      S_ADD_CMP   = 16'h0020,
      S_ADD_PUT   = 16'h0040,
      S_MAP_START = 16'h0080,
      S_MAP_READ0 = 16'h0100,
      S_MAP_PREV  = 16'h0200,
      S_MAP_READ  = 16'h0400,
      S_MAP_CUR   = 16'h0800,
      S_MAP_MUL   = 16'h1000,
      S_MAP_SUM   = 16'h2000,
      S_MAP_DIV   = 16'h4000,
      S_DONE      = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = status.is_map ? S_MAP_START : S_ADD_CHECK;
         end
         S_ADD_CHECK: begin
            if (status.chan_bad) begin
               state_in = S_DONE;
            end else if (status.table_full) begin
               cmd.set_reject = 1'b1;
               state_in       = S_DONE;
            end else begin
               cmd.set_k_count = 1'b1;
               state_in        = S_ADD_TEST;
            end
         end
         S_ADD_TEST: begin
            state_in = status.k_zero ? S_ADD_PUT : S_ADD_READ;
         end
         S_ADD_READ: begin
            cmd.rd_at_km1 = 1'b1;
            state_in      = S_ADD_CMP;
         end
         S_ADD_CMP: begin
            // Shift the larger neighbor up one slot and keep looking.
            if (status.x_less) begin
               cmd.wr_shift = 1'b1;
               cmd.dec_k    = 1'b1;
               state_in     = S_ADD_TEST;
            end else begin
               state_in = S_ADD_PUT;
            end
         end
         S_ADD_PUT: begin
            cmd.wr_point  = 1'b1;
            cmd.inc_count = 1'b1;
            state_in      = S_DONE;
         end
         S_MAP_START: begin
            if (status.few_points) begin
               state_in = S_DONE;
               if (!status.last_chan) begin
                  cmd.next_chan = 1'b1;
                  state_in      = S_MAP_START;
               end
            end else begin
               cmd.clr_k = 1'b1;
               state_in  = S_MAP_READ0;
            end
         end
         S_MAP_READ0: begin
            cmd.inc_k = 1'b1;
            state_in  = S_MAP_PREV;
         end
         S_MAP_PREV: begin
            cmd.latch_prev = 1'b1;
            state_in       = S_MAP_READ;
         end
         S_MAP_READ: begin
            state_in = S_MAP_CUR;
         end
         S_MAP_CUR: begin
            if (status.seg_found) begin
               cmd.latch_cur = 1'b1;
               state_in      = S_MAP_MUL;
            end else begin
               cmd.latch_prev = 1'b1;
               cmd.inc_k      = 1'b1;
               state_in       = S_MAP_READ;
            end
         end
         S_MAP_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_MAP_SUM;
         end
         S_MAP_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_MAP_DIV;
         end
         S_MAP_DIV: begin
            if (status.div_skip || status.div_last) begin
               cmd.div_step = !status.div_skip;
               state_in     = S_DONE;
               if (!status.last_chan) begin
                  cmd.next_chan = 1'b1;
                  state_in      = S_MAP_START;
               end
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_DONE: begin
            if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/plcm_dpath.sv
// Datapath: point tables, insertion shifter, segment search and serial divider.
// Depends on plcm_pkg and plcm_ram.
module plcm_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  plcm_pkg::cmd_type                  cmd,
   output plcm_pkg::status_type               status,
   input  logic                               req_action,
   input  logic [plcm_pkg::CH_W-1:0]          req_channel,
   input  logic signed [plcm_pkg::X_W-1:0]    req_point_x,
   input  logic signed [plcm_pkg::Y_W-1:0]    req_point_y,
   input  logic signed [plcm_pkg::X_W-1:0]    req_sample_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [plcm_pkg::COLOR_W-1:0]       rsp_red,
   output logic [plcm_pkg::COLOR_W-1:0]       rsp_green,
   output logic [plcm_pkg::COLOR_W-1:0]       rsp_blue,
   output logic                               rsp_point_rejected
);
   import plcm_pkg::*;

   // Latched request.
   logic                    action_ff;
   logic [CH_W-1:0]         channel_ff;
   logic signed [X_W-1:0]   px_ff;
   logic signed [Y_W-1:0]   py_ff;
   logic signed [X_W-1:0]   s_ff;

   // Table bookkeeping.
   logic [CNT_W-1:0]        count_ff [NUM_CHANNELS];
   logic [IDX_W-1:0]        k_ff;
   logic [CH_W-1:0]         ch_ff;
   logic [CH_W-1:0]         chan_sel;
   logic [CNT_W-1:0]        count_cur;

   // RAM signals.
   logic                    we;
   logic [ADDR_W-1:0]       waddr, raddr, chan_base;
   logic [ENTRY_W-1:0]      wdata, rdata;
   logic signed [X_W-1:0]   rd_x;
   logic signed [Y_W-1:0]   rd_y;

   // Segment and arithmetic registers.
   logic signed [X_W-1:0]   x0_ff, x1_ff;
   logic signed [Y_W-1:0]   y0_ff, y1_ff;
   logic signed [D_W-1:0]   d;
   logic signed [Y_W:0]     mul_a, dy;
   logic signed [D_W:0]     mul_b;
   logic signed [D_W-1:0]   sx;
   logic                    zero_w;
   logic signed [PROD_W-1:0] p1_ff, p2_ff;
   logic [D_W-1:0]          deff_ff;
   logic                    outside_ff;
   logic signed [NUM_W-1:0] rem_ff;
   logic [NUM_W-1:0]        div_ff;
   logic [DIV_STEPS-1:0]    q_ff, q_next;
   logic [STEP_W-1:0]       step_ff;
   logic                    ge;
   logic [COLOR_W-1:0]      color_ff [NUM_CHANNELS];
   logic [COLOR_W-1:0]      color_sat;
   logic                    reject_ff;

   // Output register.
   logic                    rsp_valid_ff;
   logic [COLOR_W-1:0]      rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                    rsp_rej_ff;

   // Channel selection and its point count.
   assign chan_sel  = (action_ff == ACT_MAP) ? ch_ff : channel_ff;
   assign count_cur = (chan_sel >= CH_W'(NUM_CHANNELS)) ? '0 : count_ff[chan_sel];
   assign chan_base = ADDR_W'(chan_sel) * ADDR_W'(MAX_POINTS);

   // Table access: reads at k or k-1, writes at k.
   assign raddr = chan_base + (cmd.rd_at_km1 ? ADDR_W'(k_ff - IDX_W'(1)) : ADDR_W'(k_ff));
   assign waddr = chan_base + ADDR_W'(k_ff);
   assign we    = cmd.wr_shift || cmd.wr_point;
   assign wdata = cmd.wr_point ? {px_ff, py_ff} : rdata;
   assign rd_x  = rdata[ENTRY_W-1 -: X_W];
   assign rd_y  = rdata[Y_W-1:0];

   plcm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   // Interpolation operands.
   assign d      = {x1_ff[X_W-1], x1_ff} - {x0_ff[X_W-1], x0_ff};
   assign zero_w = (d == '0);
   assign sx     = {s_ff[X_W-1], s_ff} - {x0_ff[X_W-1], x0_ff};
   assign dy     = {y1_ff[Y_W-1], y1_ff} - {y0_ff[Y_W-1], y0_ff};
   assign mul_a  = (zero_w ? {y1_ff[Y_W-1], y1_ff} : {y0_ff[Y_W-1], y0_ff})
                   + (Y_W+1)'(HALF_Y);
   assign mul_b  = zero_w ? (D_W+1)'(1) : {1'b0, d};

   // One restoring division step.
   assign ge        = ($unsigned(rem_ff) >= div_ff);
   assign q_next    = {q_ff[DIV_STEPS-2:0], ge};
   assign color_sat = q_next[DIV_STEPS-1] ? '1 : q_next[COLOR_W-1:0];

   // Status to the controller.
   always_comb begin
      status            = '0;
      status.is_map     = (action_ff == ACT_MAP);
      status.chan_bad   = (channel_ff >= CH_W'(NUM_CHANNELS));
      status.table_full = (count_cur >= CNT_W'(MAX_POINTS));
      status.k_zero     = (k_ff == '0);
      status.x_less     = (px_ff < rd_x);
      status.few_points = (count_cur < CNT_W'(2));
      status.seg_found  = (rd_x > s_ff) || ((CNT_W'(k_ff) + CNT_W'(1)) == count_cur);
      status.div_skip   = rem_ff[NUM_W-1] || outside_ff;
      status.div_last   = (step_ff == '0);
      status.last_chan  = (ch_ff == CH_W'(NUM_CHANNELS - 1));
      status.rsp_busy   = rsp_valid_ff && !rsp_ready;
      status.count_cur  = count_cur;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            count_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.inc_count) begin
            count_ff[chan_sel] <= count_ff[chan_sel] + CNT_W'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff  <= req_action;
         channel_ff <= req_channel;
         px_ff      <= req_point_x;
         py_ff      <= req_point_y;
         s_ff       <= req_sample_value;
         ch_ff      <= '0;
         reject_ff  <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            color_ff[i] <= '0;
         end
      end
      if (cmd.next_chan) begin
         ch_ff <= ch_ff + CH_W'(1);
      end
      if (cmd.set_reject) begin
         reject_ff <= 1'b1;
      end
      if (cmd.set_k_count) begin
         k_ff <= count_cur[IDX_W-1:0];
      end else if (cmd.dec_k) begin
         k_ff <= k_ff - IDX_W'(1);
      end else if (cmd.clr_k) begin
         k_ff <= '0;
      end else if (cmd.inc_k) begin
         k_ff <= k_ff + IDX_W'(1);
      end
      if (cmd.latch_prev) begin
         x0_ff <= rd_x;
         y0_ff <= rd_y;
      end
      if (cmd.latch_cur) begin
         x1_ff <= rd_x;
         y1_ff <= rd_y;
      end
      // Scaled numerator terms.
      if (cmd.mul) begin
         p1_ff <= mul_a * mul_b;
         if (zero_w) begin
            p2_ff <= '0;
         end else begin
            p2_ff <= dy * sx;
         end
         deff_ff    <= zero_w ? D_W'(1) : d;
         outside_ff <= (s_ff < x0_ff) || (s_ff > x1_ff);
      end
      if (cmd.sum) begin
         rem_ff  <= {p1_ff[PROD_W-1], p1_ff} + {p2_ff[PROD_W-1], p2_ff};
         div_ff  <= NUM_W'(deff_ff) << DIV_SHIFT;
         q_ff    <= '0;
         step_ff <= STEP_W'(DIV_STEPS - 1);
      end
      if (cmd.div_step) begin
         if (ge) begin
            rem_ff <= rem_ff - $signed(div_ff);
         end
         div_ff  <= div_ff >> 1;
         q_ff    <= q_next;
         step_ff <= step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            color_ff[ch_ff] <= color_sat;
         end
      end
      if (cmd.emit) begin
         rsp_red_ff   <= color_ff[0];
         rsp_green_ff <= color_ff[1];
         rsp_blue_ff  <= color_ff[2];
         rsp_rej_ff   <= reject_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_red            = rsp_red_ff;
   assign rsp_green          = rsp_green_ff;
   assign rsp_blue           = rsp_blue_ff;
   assign rsp_point_rejected = rsp_rej_ff;

endmodule

### hw/rtl/piecewise_linear_color_map_unit.sv
// Top level of the piecewise-linear color map: controller plus datapath.
// Depends on plcm_pkg, plcm_if, plcm_ctrl and plcm_dpath.
//
//   Channel   Direction  Contents
//   req_bus   in         action, channel, point_x, point_y, sample_value
//   rsp_bus   out        red, green, blue, point_rejected
//
// One request at a time. An add moves every point with a larger x up one slot
// before it writes the new point; a rejected or ignored add writes nothing. A
// lookup reads each channel's points in turn through the table RAM's single
// read port to find the segment, then uses the nine-step serial divider; a
// channel with fewer than two points is passed over. reset is synchronous and
// clears all counts. A response waiting in the output register does not stop
// the next request; it stalls only at the finishing step.
module piecewise_linear_color_map_unit (
   input logic    clock,
   input logic    reset,
   plcm_req_if.sink   req_bus,
   plcm_rsp_if.source rsp_bus
);
   import plcm_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_fire;

   assign req_fire = req_bus.valid && req_bus.ready;

   plcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .status    (status),
      .req_ready (req_bus.ready),
      .cmd       (cmd)
   );

   plcm_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_action         (req_bus.action),
      .req_channel        (req_bus.channel),
      .req_point_x        (req_bus.point_x),
      .req_point_y        (req_bus.point_y),
      .req_sample_value   (req_bus.sample_value),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_red            (rsp_bus.red),
      .rsp_green          (rsp_bus.green),
      .rsp_blue           (rsp_bus.blue),
      .rsp_point_rejected (rsp_bus.point_rejected)
   );

   // A request in flight blocks the next one.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_bus.ready)
      else $error("request accepted while another is in flight");

   // No table ever holds more than its capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      status.count_cur <= CNT_W'(MAX_POINTS))
      else $error("point count above capacity");

   // Reset leaves no response pending.
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("response valid right after reset");

   // A response is only issued when the output register is empty or its response is being taken.
   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !status.rsp_busy)
      else $error("response overwritten before it was taken");

endmodule

### tb/sv/piecewise_linear_color_map_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_linear_color_map_unit: point inserts and lookups
// are checked against a scoreboard that keeps its own copy of the three point tables.
// Depends on plcm_pkg, plcm_if and the RTL of the block.

// Channel selector codes for point inserts.
localparam logic [1:0] SEL_RED   = 2'd0;
localparam logic [1:0] SEL_GREEN = 2'd1;
localparam logic [1:0] SEL_BLUE  = 2'd2;
localparam logic [1:0] SEL_NONE  = 2'd3;

typedef struct packed {
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       rejected;
} color_result_type;

class color_map_scoreboard;
   longint           pos_x[3][16];
   longint           level_y[3][16];
   int               fill[3];
   color_result_type expected_colors[$];
   int               mismatches;
   int               checked;
   int               rejects;

   function new();
      fill = '{0, 0, 0};
      mismatches = 0;
      checked = 0;
      rejects = 0;
   endfunction

   function int pending();
      return expected_colors.size();
   endfunction

   // Level of one channel at sample s, rounded and clamped to 0..255.
   function automatic logic [7:0] channel_level(int ch, longint s);
      int     n;
      int     i;
      longint x0, x1, y0, y1, d, num, q;
      n = fill[ch];
      if (n < 2) return 8'd0;
      i = 1;
      while (i < n && pos_x[ch][i] <= s) i++;
      if (i == n) i--;
      x0 = pos_x[ch][i-1];
      x1 = pos_x[ch][i];
      if (s < x0 || s > x1) return 8'd0;
      y0 = level_y[ch][i-1];
      y1 = level_y[ch][i];
      d = x1 - x0;
      if (d == 0) begin
         // A zero-width segment gives its right level.
         num = y1 + 128;
         d = 1;
      end else begin
         num = y0 * d + (y1 - y0) * (s - x0) + 128 * d;
      end
      if (num < 0) return 8'd0;
      q = num / (256 * d);
      if (q > 255) return 8'd255;
      return q[7:0];
   endfunction

   // Applies an accepted request to the tables and queues its response.
   function void note_request(logic act, logic [1:0] sel, logic signed [31:0] px,
                              logic signed [17:0] py, logic signed [31:0] sample);
      color_result_type r;
      int               ch;
      int               at;
      r = '0;
      if (act == plcm_pkg::ACT_ADD) begin
         if (sel != SEL_NONE) begin
            ch = sel;
            if (fill[ch] >= 16) begin
               r.rejected = 1'b1;
               rejects++;
            end else begin
               // Insert after any point with an equal x.
               at = fill[ch];
               for (int k = 0; k < fill[ch]; k++)
                  if (longint'(px) < pos_x[ch][k]) begin
                     at = k;
                     break;
                  end
               for (int k = fill[ch]; k > at; k--) begin
                  pos_x[ch][k] = pos_x[ch][k-1];
                  level_y[ch][k] = level_y[ch][k-1];
               end
               pos_x[ch][at] = longint'(px);
               level_y[ch][at] = longint'(py);
               fill[ch]++;
            end
         end
      end else begin
         r.red   = channel_level(0, longint'(sample));
         r.green = channel_level(1, longint'(sample));
         r.blue  = channel_level(2, longint'(sample));
      end
      expected_colors.insert(expected_colors.size(), r);
   endfunction

   // Compares one response with the oldest expectation.
   function void check_response(color_result_type got);
      color_result_type want;
      checked++;
      if (expected_colors.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: response with none expected: %p", got);
         return;
      end
      want = expected_colors.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue
          || got.rejected !== want.rejected) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: rgb/rej expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                     want.red, want.green, want.blue, want.rejected,
                     got.red, got.green, got.blue, got.rejected);
      end
   endfunction

   // Sample near a random point of a random channel; anywhere if that channel is empty, and one time in ten.
   function logic signed [31:0] sample_near_point();
      int ch;
      ch = $urandom_range(0, 2);
      if (fill[ch] == 0 || $urandom_range(0, 9) == 0) return $urandom;
      return 32'(pos_x[ch][$urandom_range(0, fill[ch] - 1)]
                 + longint'($urandom_range(0, 32'h40000)) - 64'h20000);
   endfunction
endclass

module piecewise_linear_color_map_unit_test;
   localparam int STALL_LIMIT     = 5000;
   localparam int RSP_HOLD_CYCLES = 400;

   logic clock;
   logic reset;
   int   req_idle_pct;
   int   rsp_idle_pct;
   logic hold_rsp = 1'b0;
   logic hold_done = 1'b0;
   int   rsp_hold = 0;
   int   quiet_cycles = 0;
   int   lookups_sent;
   int   inserts_sent;

   color_map_scoreboard colors;

   plcm_req_if req_bus();
   plcm_rsp_if rsp_bus();

   piecewise_linear_color_map_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offers one request, idling at random first, and waits for it to be taken.
   task automatic send_request(logic act, logic [1:0] sel, logic signed [31:0] px,
                               logic signed [17:0] py, logic signed [31:0] sample);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= act;
      req_bus.channel      <= sel;
      req_bus.point_x      <= px;
      req_bus.point_y      <= py;
      req_bus.sample_value <= sample;
      do @(posedge clock); while (!req_bus.ready);
      colors.note_request(act, sel, px, py, sample);
      if (act == plcm_pkg::ACT_MAP) lookups_sent++;
      else inserts_sent++;
   endtask

   task automatic add_point(logic [1:0] sel, logic signed [31:0] px, logic signed [17:0] py);
      send_request(plcm_pkg::ACT_ADD, sel, px, py, $urandom);
   endtask

   task automatic look_up(logic signed [31:0] sample);
      send_request(plcm_pkg::ACT_MAP, 2'($urandom), $urandom, 18'($urandom), sample);
   endtask

   // Response ready, with random idling and one long counted hold-off.
   always @(posedge clock) begin
      if (hold_rsp && !hold_done) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold      <= rsp_hold + 1;
         if (rsp_hold >= RSP_HOLD_CYCLES - 1) hold_done <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // Response checking.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         colors.check_response(color_result_type'{rsp_bus.red, rsp_bus.green,
                                                  rsp_bus.blue, rsp_bus.point_rejected});
   end

   // Watchdog on cycles with no handshake on either side.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic signed [31:0] px;
      logic signed [17:0] py;
      colors = new();
      req_idle_pct = 27;
      rsp_idle_pct = 27;
      lookups_sent = 0;
      inserts_sent = 0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.action <= plcm_pkg::ACT_ADD;
      req_bus.channel <= SEL_RED;
      req_bus.point_x <= '0;
      req_bus.point_y <= '0;
      req_bus.sample_value <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty tables, ignored selector, single point, plain segment.
      look_up(32'sh0);
      add_point(SEL_NONE, 32'sh8000_0000, 18'sh2_0000);
      add_point(SEL_RED, 32'sh0, 18'sh0);
      look_up(32'sh0);
      add_point(SEL_RED, 32'sh1_0000, 18'sd65280);
      look_up(32'sh8000);
      look_up(-32'sd1);
      look_up(32'sh2_0000);
      // Equal x goes after the existing point: zero-width segment, clamped high.
      add_point(SEL_RED, 32'sh1_0000, 18'sh1_FFFF);
      look_up(32'sh1_0000);
      // Widest possible segment with extreme levels.
      add_point(SEL_GREEN, 32'sh8000_0000, 18'sh2_0000);
      add_point(SEL_GREEN, 32'sh7FFF_FFFF, 18'sh1_FFFF);
      look_up(32'sh8000_0000);
      look_up(32'sh7FFF_FFFF);
      look_up(32'sh0);
      // Negative levels clamp to zero.
      add_point(SEL_BLUE, 32'sh0, -18'sd256);
      add_point(SEL_BLUE, 32'sh100, -18'sd256);
      look_up(32'sh80);

      // Random: inserts fill the tables until they reject, lookups land near points.
      for (int n = 0; n < 1550; n++) begin
         if (n == 600) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (n == 800) begin
            req_idle_pct = 27;
            rsp_idle_pct = 27;
         end
         // Hold responses off while requests keep coming.
         if (n == 1000) hold_rsp = 1'b1;
         // Let the block drain completely before going on.
         if (n == 1200) begin
            req_bus.valid <= 1'b0;
            while (colors.pending() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 99) < 12) begin
            px = $urandom_range(0, 9) == 0 ? 32'($urandom)
                 : 32'(int'($urandom_range(0, 32'h10_0000)) - 32'h8_0000);
            py = $urandom_range(0, 7) == 0 ? 18'($urandom)
                 : 18'(int'($urandom_range(0, 90000)) - 20000);
            add_point(2'($urandom), px, py);
         end else begin
            look_up(colors.sample_near_point());
         end
      end
      req_bus.valid <= 1'b0;

      while (colors.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d lookups and %0d point inserts, %0d inserts rejected on full tables.",
               lookups_sent, inserts_sent, colors.rejects);
      $display("Checked %0d responses, %0d mismatches.", colors.checked, colors.mismatches);
      if (colors.mismatches == 0 && colors.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

### filelist.f
hw/rtl/plcm_pkg.sv
hw/rtl/plcm_if.sv
hw/rtl/plcm_ram.sv
hw/rtl/plcm_ctrl.sv
hw/rtl/plcm_dpath.sv
hw/rtl/piecewise_linear_color_map_unit.sv
tb/sv/piecewise_linear_color_map_unit_test.sv
